// ===== hw/rtl/pcsl_pkg.sv =====
package pcsl_pkg;

   // board and store geometry
   localparam int MAX_CELLS   = 1024;
   localparam int POS_W       = 10;
   localparam int CELL_W      = 3;
   localparam int BYTE_W      = 8;
   localparam int STORE_BYTES = (CELL_W * MAX_CELLS + BYTE_W - 1) / BYTE_W;
   localparam int BIT_W       = $clog2(CELL_W * MAX_CELLS);
   localparam int BYTE_AW     = $clog2(STORE_BYTES);
   localparam int NBYTES_W    = $clog2(STORE_BYTES + 1);
   localparam int BANK_DEPTH  = (STORE_BYTES + 1) / 2;
   localparam int BANK_AW     = $clog2(BANK_DEPTH);
   localparam int COUNT_W     = $clog2(MAX_CELLS + 1);

   // register file
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int DIM_W       = 6;
   localparam int PROD_W      = 2 * DIM_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 2'd2;

   // transaction modes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SEED  = 2'd3;

   // generator
   localparam int GEN_W = 32;
   localparam logic [GEN_W-1:0] LCG_MUL = 32'd1103515245;
   localparam logic [GEN_W-1:0] LCG_ADD = 32'd12345;
   localparam logic [GEN_W-1:0] GEN_RESET = 32'd1;
   localparam int RND_LSB = 16;
   localparam int RND_W   = 15;

   // x / 6 as (x * ceil(2^18 / 6)) >> 18, exact for x below 2^15
   localparam int DIV6_SHIFT = 18;
   localparam int DIV6_MUL_W = 16;
   localparam logic [DIV6_MUL_W-1:0] DIV6_MUL = 16'd43691;

   typedef struct packed {
      logic                  rd_en;
      logic [POS_W-1:0]      rd_pos;
      logic                  wr_en;
      logic [CELL_W-1:0]     wr_value;
      logic                  clr_en;
      logic [BANK_AW-1:0]    clr_addr;
      logic                  clr_even;
      logic                  clr_odd;
   } pcsl_store_req_type;

endpackage

// ===== hw/rtl/pcsl_cell_store.sv =====
module pcsl_cell_store (
   input  logic                          clock,
   input  pcsl_pkg::pcsl_store_req_type  store_req,
   output logic [pcsl_pkg::CELL_W-1:0]   rd_cell
);
   import pcsl_pkg::*;

   // even and odd bytes live in separate banks so a straddling cell is one access
   logic [BYTE_W-1:0] bank_even_ff [BANK_DEPTH];
   logic [BYTE_W-1:0] bank_odd_ff  [BANK_DEPTH];

   logic [BIT_W-1:0]    bit_pos;
   logic [BYTE_AW-1:0]  byte_idx;
   logic                idx_odd;
   logic [BANK_AW-1:0]  pair_addr;
   logic [BANK_AW-1:0]  pair_next;
   logic                has_hi;
   logic [BANK_AW-1:0]  even_ra;

   logic                odd_ff;
   logic [BANK_AW-1:0]  pair_ff;
   logic [BANK_AW-1:0]  pair_next_ff;
   logic [2:0]          off_ff;
   logic                has_hi_ff;
   logic [BYTE_W-1:0]   even_q_ff;
   logic [BYTE_W-1:0]   odd_q_ff;

   logic [BYTE_W-1:0]   win_lo;
   logic [BYTE_W-1:0]   win_hi;
   logic [2*BYTE_W-1:0] win;
   logic [2*BYTE_W-1:0] win_shifted;
   logic [2*BYTE_W-1:0] cell_mask;
   logic [2*BYTE_W-1:0] merged;

   logic                even_we;
   logic [BANK_AW-1:0]  even_wa;
   logic [BYTE_W-1:0]   even_wd;
   logic                odd_we;
   logic [BANK_AW-1:0]  odd_wa;
   logic [BYTE_W-1:0]   odd_wd;

   always_comb begin
      bit_pos   = (BIT_W'(store_req.rd_pos) << 1) + BIT_W'(store_req.rd_pos);
      byte_idx  = BYTE_AW'(bit_pos >> 3);
      idx_odd   = byte_idx[0];
      pair_addr = BANK_AW'(byte_idx >> 1);
      has_hi    = ({1'b0, byte_idx} + 1'b1) < (BYTE_AW + 1)'(STORE_BYTES);
      // top pair has no successor; its upper byte is never used there
      pair_next = (pair_addr == BANK_AW'(BANK_DEPTH - 1)) ? pair_addr : pair_addr + 1'b1;
      even_ra   = idx_odd ? pair_next : pair_addr;
   end

   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         odd_ff       <= idx_odd;
         pair_ff      <= pair_addr;
         pair_next_ff <= pair_next;
         off_ff       <= bit_pos[2:0];
         has_hi_ff    <= has_hi;
         even_q_ff    <= bank_even_ff[even_ra];
         odd_q_ff     <= bank_odd_ff[pair_addr];
      end
   end

   always_comb begin
      win_lo      = odd_ff ? odd_q_ff : even_q_ff;
      win_hi      = odd_ff ? even_q_ff : odd_q_ff;
      win         = {win_hi, win_lo};
      win_shifted = win >> off_ff;
      rd_cell     = win_shifted[CELL_W-1:0];
      cell_mask   = (2*BYTE_W)'({CELL_W{1'b1}}) << off_ff;
      merged      = (win & ~cell_mask) | ((2*BYTE_W)'(store_req.wr_value) << off_ff);
   end

   always_comb begin
      if (store_req.clr_en) begin
         even_we = store_req.clr_even;
         even_wa = store_req.clr_addr;
         even_wd = '0;
         odd_we  = store_req.clr_odd;
         odd_wa  = store_req.clr_addr;
         odd_wd  = '0;
      end else begin
         even_we = store_req.wr_en && (!odd_ff || has_hi_ff);
         even_wa = odd_ff ? pair_next_ff : pair_ff;
         even_wd = odd_ff ? merged[2*BYTE_W-1:BYTE_W] : merged[BYTE_W-1:0];
         odd_we  = store_req.wr_en;
         odd_wa  = pair_ff;
         odd_wd  = odd_ff ? merged[BYTE_W-1:0] : merged[2*BYTE_W-1:BYTE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (even_we) begin
         bank_even_ff[even_wa] <= even_wd;
      end
      if (odd_we) begin
         bank_odd_ff[odd_wa] <= odd_wd;
      end
   end

endmodule

// ===== hw/rtl/packed_cell_store_lcg_fill_top.sv =====
// Packed 3-bit cell store with pseudo-random fill. Cells sit three bits apiece
// in a byte store split into an even-byte and an odd-byte bank (one read port
// each, registered read), so any cell, even one that straddles two bytes, is
// read in a single access and written back in the next cycle. Read and write
// transactions go through accept, then read-modify-write. A fill of
// N = rows*columns cells first clears its B = ceil(3*N/8) bytes, one byte pair
// per cycle, then does one read then one write per cell. A fill beyond
// capacity or of an empty board completes without touching the store. After
// reset the store is swept to zero, one byte pair per cycle, during which no
// transaction is taken (register writes are). The next transaction is taken
// while a result still waits on the output register.
module packed_cell_store_lcg_fill_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pcsl_pkg::MODE_W-1:0]       req_mode,
   input  logic [pcsl_pkg::POS_W-1:0]        req_position,
   input  logic [pcsl_pkg::CELL_W-1:0]       req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pcsl_pkg::CELL_W-1:0]       rsp_cell_value,
   output logic                              rsp_out_of_range,
   input  logic                              csr_write_enable,
   input  logic [pcsl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pcsl_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import pcsl_pkg::*;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] S_CLEAR   = 3'd0;
   localparam logic [ST_W-1:0] S_IDLE    = 3'd1;
   localparam logic [ST_W-1:0] S_ACCESS  = 3'd2;
   localparam logic [ST_W-1:0] S_FILL_RD = 3'd3;
   localparam logic [ST_W-1:0] S_FILL_WR = 3'd4;
   localparam logic [ST_W-1:0] S_DONE    = 3'd5;

   logic [ST_W-1:0]        state_ff, state_in;
   logic [GEN_W-1:0]       gen_ff, gen_in;
   logic [CSR_DATA_W-1:0]  seed_ff;
   logic [DIM_W-1:0]       rows_ff;
   logic [DIM_W-1:0]       columns_ff;
   logic [NBYTES_W-1:0]    nbytes_ff, nbytes_in;
   logic [BANK_AW-1:0]     clr_ff, clr_in;
   logic                   fill_ff, fill_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   wr_ff, wr_in;
   logic [CELL_W-1:0]      value_ff, value_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [CELL_W-1:0]      res_cell_ff, res_cell_in;
   logic                   res_flag_ff, res_flag_in;
   logic [CELL_W-1:0]      rsp_cell_ff, rsp_cell_in;
   logic                   rsp_flag_ff, rsp_flag_in;

   pcsl_store_req_type     store_req;
   logic [CELL_W-1:0]      rd_cell;

   logic                   req_accept;
   logic                   out_free;
   logic                   fin_en;
   logic [CELL_W-1:0]      fin_cell;
   logic                   fin_flag;
   logic [PROD_W-1:0]      cell_count;
   logic [PROD_W+1:0]      bits_round;
   logic [NBYTES_W:0]      clr_byte;
   logic                   clr_last;
   logic [RND_W-1:0]       rnd;
   logic [RND_W+DIV6_MUL_W-1:0] div_prod;
   logic [RND_W+DIV6_MUL_W-DIV6_SHIFT-1:0] quot;
   logic [CELL_W-1:0]      quot6;
   logic [CELL_W-1:0]      rnd_mod6;
   logic                   fill_last;

   pcsl_cell_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_cell   (rd_cell)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign req_accept       = req_valid && !req_stall;
   assign out_free         = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_value   = rsp_cell_ff;
   assign rsp_out_of_range = rsp_flag_ff;

   always_comb begin
      cell_count = PROD_W'(rows_ff) * PROD_W'(columns_ff);
      bits_round = (PROD_W + 2)'(cell_count) + ((PROD_W + 2)'(cell_count) << 1) + (PROD_W + 2)'(7);
      clr_byte   = (NBYTES_W + 1)'({clr_ff, 1'b0});
      clr_last   = (clr_byte + (NBYTES_W + 1)'(2)) >= {1'b0, nbytes_ff};
      // draw mod 6 from the freshly stepped generator
      rnd        = gen_ff[RND_LSB +: RND_W];
      div_prod   = (RND_W + DIV6_MUL_W)'(rnd) * (RND_W + DIV6_MUL_W)'(DIV6_MUL);
      quot       = div_prod[RND_W+DIV6_MUL_W-1:DIV6_SHIFT];
      quot6      = CELL_W'({quot[0], 2'b00}) + CELL_W'({quot[1:0], 1'b0});
      rnd_mod6   = rnd[CELL_W-1:0] - quot6;
      fill_last  = (COUNT_W'(pos_ff) + 1'b1) == count_ff;
   end

   always_comb begin
      state_in    = state_ff;
      gen_in      = gen_ff;
      nbytes_in   = nbytes_ff;
      clr_in      = clr_ff;
      fill_in     = fill_ff;
      wr_in       = wr_ff;
      value_in    = value_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      fin_en      = 1'b0;
      fin_cell    = '0;
      fin_flag    = 1'b0;
      store_req   = '0;

      unique case (state_ff)
         S_CLEAR: begin
            store_req.clr_en   = 1'b1;
            store_req.clr_addr = clr_ff;
            store_req.clr_even = clr_byte < {1'b0, nbytes_ff};
            store_req.clr_odd  = (clr_byte + 1'b1) < {1'b0, nbytes_ff};
            if (clr_last) begin
               clr_in   = '0;
               pos_in   = '0;
               state_in = fill_ff ? S_FILL_RD : S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_mode)
                  MODE_WRITE, MODE_READ: begin
                     if ((COUNT_W + 1)'(req_position) >= (COUNT_W + 1)'(MAX_CELLS)) begin
                        fin_flag = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        store_req.rd_en  = 1'b1;
                        store_req.rd_pos = req_position;
                        wr_in            = (req_mode == MODE_WRITE);
                        value_in         = req_value;
                        state_in         = S_ACCESS;
                     end
                  end
                  MODE_FILL: begin
                     if (cell_count > PROD_W'(MAX_CELLS)) begin
                        fin_flag = 1'b1;
                        state_in = S_DONE;
                     end else if (cell_count == '0) begin
                        state_in = S_DONE;
                     end else begin
                        count_in  = COUNT_W'(cell_count);
                        nbytes_in = NBYTES_W'(bits_round >> 3);
                        clr_in    = '0;
                        fill_in   = 1'b1;
                        state_in  = S_CLEAR;
                     end
                  end
                  MODE_SEED: begin
                     gen_in   = seed_ff;
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ACCESS: begin
            store_req.wr_en    = wr_ff;
            store_req.wr_value = value_ff;
            fin_en             = 1'b1;
            fin_cell           = wr_ff ? '0 : rd_cell;
         end
         S_FILL_RD: begin
            store_req.rd_en  = 1'b1;
            store_req.rd_pos = pos_ff;
            gen_in           = gen_ff * LCG_MUL + LCG_ADD;
            state_in         = S_FILL_WR;
         end
         S_FILL_WR: begin
            store_req.wr_en    = 1'b1;
            store_req.wr_value = rnd_mod6;
            if (fill_last) begin
               fill_in = 1'b0;
               fin_en  = 1'b1;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = S_FILL_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a finished transaction goes straight out when the output register frees up
      if (fin_en) begin
         state_in = out_free ? S_IDLE : S_DONE;
      end
   end

   always_comb begin
      res_cell_in  = res_cell_ff;
      res_flag_in  = res_flag_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == S_IDLE && req_accept) begin
         res_cell_in = '0;
         res_flag_in = fin_flag;
      end
      if (fin_en) begin
         if (out_free) begin
            rsp_cell_in  = fin_cell;
            rsp_flag_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            res_cell_in = fin_cell;
            res_flag_in = 1'b0;
         end
      end else if (state_ff == S_DONE && out_free) begin
         rsp_cell_in  = res_cell_ff;
         rsp_flag_in  = res_flag_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         gen_ff       <= GEN_RESET;
         seed_ff      <= CSR_DATA_W'(1);
         rows_ff      <= DIM_W'(8);
         columns_ff   <= DIM_W'(8);
         nbytes_ff    <= NBYTES_W'(STORE_BYTES);
         clr_ff       <= '0;
         fill_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         nbytes_ff    <= nbytes_in;
         clr_ff       <= clr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_SEED:    seed_ff    <= csr_write_data;
               CSR_ROWS:    rows_ff    <= csr_write_data[DIM_W-1:0];
               CSR_COLUMNS: columns_ff <= csr_write_data[DIM_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_ff       <= wr_in;
      value_ff    <= value_in;
      pos_ff      <= pos_in;
      count_ff    <= count_in;
      res_cell_ff <= res_cell_in;
      res_flag_ff <= res_flag_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   // clearing sweep stays inside the bytes it was asked to clear
   a_clear_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (clr_byte < {1'b0, nbytes_ff}))
      else $error("clearing sweep beyond its byte span");

   // fill walk stays below the cell count
   a_fill_in_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL_RD || state_ff == S_FILL_WR) |-> (COUNT_W'(pos_ff) < count_ff))
      else $error("fill position past cell count");

   // every accepted transaction is out of idle in the cycle after acceptance
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("idle right after accepting a transaction");

   // a flagged result never carries a cell value
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_cell_value == '0))
      else $error("out-of-range result with a cell value");

   // generator moves only on a fill step or a seed load
   a_gen_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FILL_RD && !(req_accept && req_mode == MODE_SEED)) |=> $stable(gen_ff))
      else $error("generator changed outside fill or seed load");

endmodule
